// ----- hdl/swt_pkg.sv -----
// ----------------------------------------------------------------------------
// String whitelist table package
// Shared constants and the control bundle that the top level sends to each
// entry cell.
// ----------------------------------------------------------------------------
package swt_pkg;

   // Default table shape.
   localparam int ENTRIES_DEFAULT    = 8;
   localparam int SLOT_BYTES_DEFAULT = 32;

   // Field widths on the streaming ports.
   localparam int CH_W        = 8;
   localparam int USED_W      = 4;
   localparam int RSP_PAYLD_W = 1 + USED_W;
   localparam int RSP_DATA_W  = ((RSP_PAYLD_W + 7) / 8) * 8;

   // Operation codes carried on tuser.
   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_FIND = 1'b1;

   // Per-byte control broadcast from the sequencer to every cell.
   typedef struct packed {
      logic              accept;    // a byte transfer happens this cycle
      logic              start;     // byte is the first of a string
      logic              find_mode; // effective operation is find
      logic              write_ok;  // add may still store bytes
      logic              saturated; // position is past the slot end
      logic              commit_ok; // add terminator that fits the slot
      logic [CH_W-1:0]   ch;        // character being processed
   } cell_ctrl_type;

endpackage

// ----- hdl/swt_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module swt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; returns the old contents on a same-address write.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/swt_cell.sv -----
// ----------------------------------------------------------------------------
// String whitelist table entry cell
// Holds one slot of the table, its occupied bit and its running match flag.
// Hands its occupied bit to the next cell so the first free cell takes adds.
// ----------------------------------------------------------------------------
module swt_cell #(
   parameter int SLOT_BYTES = swt_pkg::SLOT_BYTES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  swt_pkg::cell_ctrl_type        ctrl,
   input  logic [$clog2(SLOT_BYTES)-1:0] wr_addr,
   input  logic [$clog2(SLOT_BYTES)-1:0] rd_addr,
   input  logic                          prev_used,
   output logic                          used,
   output logic                          hit
);

   localparam int AW = $clog2(SLOT_BYTES);

   logic                    used_ff;
   logic                    used_in;
   logic                    match_ff;
   logic                    match_in;
   logic                    flag_cur;
   logic                    target;
   logic                    wr_en;
   logic [swt_pkg::CH_W-1:0] rd_data;

   // Slot storage.
   swt_ram #(
      .WIDTH (swt_pkg::CH_W),
      .DEPTH (SLOT_BYTES)
   ) u_slot (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr[AW-1:0]),
      .wr_data (ctrl.ch),
      .rd_addr (rd_addr[AW-1:0]),
      .rd_data (rd_data)
   );

   // This cell is the free slot when it is empty and the cell before it is used.
   assign target = !used_ff && prev_used;

   // Match flag restarts at the first byte of each string.
   assign flag_cur = ctrl.start ? 1'b1 : match_ff;
   assign hit      = flag_cur && used_ff && !ctrl.saturated && (rd_data == ctrl.ch);

   // Add writes bytes only into the free slot while they still fit.
   assign wr_en = ctrl.accept && !ctrl.find_mode && ctrl.write_ok && target;

   always_comb begin
      match_in = match_ff;
      used_in  = used_ff;
      if (ctrl.accept && ctrl.find_mode) begin
         match_in = hit;
      end
      if (ctrl.accept && ctrl.commit_ok && target) begin
         used_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= 1'b0;
         match_ff <= 1'b1;
      end else begin
         used_ff  <= used_in;
         match_ff <= match_in;
      end
   end

   assign used = used_ff;

endmodule

// ----- hdl/string_whitelist_table.sv -----
// ----------------------------------------------------------------------------
// String whitelist table
// Stores up to ENTRIES zero-terminated strings and answers add and find
// requests with a row of entry cells that compare in parallel.
// ----------------------------------------------------------------------------
// The block takes one string byte per cycle; tuser at a string's first byte
// selects add or find, and a zero byte ends the string. Each entry cell keeps
// its slot in a RAM with registered read, and the next byte position is read
// ahead so every byte is compared against all entries in the cycle it
// arrives. The result of an operation appears on the response side in the
// cycle after its terminating byte is accepted. After the terminator of an
// add string the input pauses, because the slot RAMs must re-read the first
// byte position after that write. A result that waits on the response sink
// holds off the input until it is taken; otherwise every byte sustains one
// transfer per cycle. There is no clearing pass after reset: the table starts
// empty and a slot is only compared up to bytes that were written into it.
module string_whitelist_table #(
   parameter int ENTRIES    = swt_pkg::ENTRIES_DEFAULT,
   parameter int SLOT_BYTES = swt_pkg::SLOT_BYTES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request stream.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [swt_pkg::CH_W-1:0]       req_tdata,  // [7:0] ch
   input  logic                           req_tuser,  // [0] mode
   // Response stream.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [swt_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [0] success, [4:1] entries_used
   output logic                           rsp_tuser   // [0] op
);

   localparam int AW = $clog2(SLOT_BYTES);
   localparam int PW = $clog2(SLOT_BYTES + 1);
   localparam int CW = $clog2(ENTRIES + 1);

   logic [PW-1:0] pos_ff;
   logic [PW-1:0] pos_in;
   logic          mode_ff;
   logic          mode_in;
   logic          too_long_ff;
   logic          too_long_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          hold_ff;
   logic          hold_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic [swt_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic [swt_pkg::RSP_DATA_W-1:0] rsp_data_in;
   logic          rsp_op_ff;
   logic          rsp_op_in;

   logic          accept;
   logic          start;
   logic          mode_eff;
   logic          too_long_eff;
   logic          saturated;
   logic          term;
   logic          add_ok;
   logic          find_ok;
   logic [PW-1:0] rd_pos;
   logic [CW+swt_pkg::USED_W-1:0] count_ext;

   swt_pkg::cell_ctrl_type cell_ctrl;
   logic [ENTRIES:0]       used_chain;
   logic [ENTRIES-1:0]     hits;

   // Input handshake: wait out the RAM refresh and a pending response.
   assign req_tready = !hold_ff && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   // Per-byte decode.
   assign start        = (pos_ff == '0);
   assign mode_eff     = start ? req_tuser : mode_ff;
   assign too_long_eff = start ? 1'b0 : too_long_ff;
   assign saturated    = (pos_ff == PW'(SLOT_BYTES));
   assign term         = (req_tdata == '0);

   assign cell_ctrl.accept    = accept;
   assign cell_ctrl.start     = start;
   assign cell_ctrl.find_mode = (mode_eff == swt_pkg::OP_FIND);
   assign cell_ctrl.write_ok  = !saturated && !too_long_eff;
   assign cell_ctrl.saturated = saturated;
   assign cell_ctrl.commit_ok = (mode_eff == swt_pkg::OP_ADD) && term && !too_long_eff;
   assign cell_ctrl.ch        = req_tdata;

   // Read ahead at the position the next byte will use.
   assign rd_pos = accept ? pos_in : pos_ff;

   // Row of entry cells; the first cell sees a used neighbor.
   assign used_chain[0] = 1'b1;

   for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_cell
      swt_cell #(
         .SLOT_BYTES (SLOT_BYTES)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl),
         .wr_addr   (pos_ff[AW-1:0]),
         .rd_addr   (rd_pos[AW-1:0]),
         .prev_used (used_chain[gi]),
         .used      (used_chain[gi+1]),
         .hit       (hits[gi])
      );
   end

   // String sequencing and entry count.
   always_comb begin
      pos_in      = pos_ff;
      mode_in     = mode_ff;
      too_long_in = too_long_ff;
      count_in    = count_ff;
      hold_in     = 1'b0;
      add_ok      = cell_ctrl.commit_ok && (count_ff < CW'(ENTRIES));
      find_ok     = |hits;
      if (accept) begin
         mode_in = mode_eff;
         if (term) begin
            pos_in      = '0;
            too_long_in = 1'b0;
            if (add_ok) begin
               count_in = count_ff + CW'(1);
            end
            hold_in = (mode_eff == swt_pkg::OP_ADD);
         end else begin
            too_long_in = too_long_eff || (pos_ff >= PW'(SLOT_BYTES - 1));
            if (!saturated) begin
               pos_in = pos_ff + PW'(1);
            end
         end
      end
   end

   // Response register.
   assign count_ext = {{swt_pkg::USED_W{1'b0}}, count_in};

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_op_in    = rsp_op_ff;
      if (accept && term) begin
         rsp_valid_in = 1'b1;
         rsp_op_in    = mode_eff;
         rsp_data_in  = '0;
         rsp_data_in[0] = (mode_eff == swt_pkg::OP_FIND) ? find_ok : add_ok;
         rsp_data_in[swt_pkg::USED_W:1] = count_ext[swt_pkg::USED_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         mode_ff      <= swt_pkg::OP_ADD;
         too_long_ff  <= 1'b0;
         count_ff     <= '0;
         hold_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         mode_ff      <= mode_in;
         too_long_ff  <= too_long_in;
         count_ff     <= count_in;
         hold_ff      <= hold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_op_ff   <= rsp_op_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_op_ff;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// String whitelist table testbench
// Streams add and find strings into the table one byte per transfer and
// checks every response against a cycle-free model of the table kept here.
// Directed tests cover empty strings, the slot length limit, character
// extremes and a full table. Random traffic then mixes exact, near-miss and
// over-long strings, with and without random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module testbench;

   localparam int ENTRIES     = swt_pkg::ENTRIES_DEFAULT;
   localparam int SLOT_BYTES  = swt_pkg::SLOT_BYTES_DEFAULT;
   localparam int CH_W        = swt_pkg::CH_W;
   localparam int USED_W      = swt_pkg::USED_W;
   localparam int RSP_DATA_W  = swt_pkg::RSP_DATA_W;
   localparam int MAX_TEXT    = 48;
   localparam int CYCLE_LIMIT = 600000;

   typedef logic [CH_W-1:0] text_buf_type [0:MAX_TEXT-1];

   // One response as the table should report it.
   typedef struct packed {
      logic              op;
      logic              success;
      logic [USED_W-1:0] used;
   } outcome_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [CH_W-1:0]       req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   // Table model state.
   logic [CH_W-1:0]    stored_bytes [0:ENTRIES-1][0:SLOT_BYTES-1];
   int                 stored_count    = 0;
   int                 scan_pos        = 0;
   logic [ENTRIES-1:0] live_entries    = '1;
   logic               string_mode     = swt_pkg::OP_ADD;
   logic               string_overflow = 1'b0;
   outcome_type        pending_outcomes [$];

   // Run control and statistics.
   bit src_gaps    = 1'b0;
   bit sink_stalls = 1'b0;
   int stall_left  = 0;
   int cycle_count = 0;
   int bytes_sent  = 0;
   int mismatch_count = 0;
   int checked_count  = 0;
   int adds_stored = 0, adds_rejected = 0, finds_hit = 0, finds_absent = 0;

   string_whitelist_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Clock: 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Advance the table model by one accepted byte; queue a response on a
   // terminator.
   function automatic void track_string_byte(input logic mode_bit,
                                             input logic [CH_W-1:0] ch);
      outcome_type res;
      if (scan_pos == 0) begin
         string_mode     = mode_bit;
         live_entries    = '1;
         string_overflow = 1'b0;
      end
      if (string_mode == swt_pkg::OP_ADD) begin
         if (stored_count < ENTRIES && scan_pos < SLOT_BYTES && !string_overflow)
            stored_bytes[stored_count][scan_pos] = ch;
      end else begin
         for (int e = 0; e < ENTRIES; e++) begin
            if (live_entries[e] && (e >= stored_count || scan_pos >= SLOT_BYTES ||
                                    stored_bytes[e][scan_pos] != ch))
               live_entries[e] = 1'b0;
         end
      end
      if (ch != 0) begin
         if (scan_pos >= SLOT_BYTES - 1) string_overflow = 1'b1;
         if (scan_pos < SLOT_BYTES) scan_pos++;
         return;
      end
      res.op      = string_mode;
      res.success = 1'b0;
      if (string_mode == swt_pkg::OP_ADD) begin
         if (!string_overflow && stored_count < ENTRIES) begin
            stored_count++;
            res.success = 1'b1;
         end
         if (res.success) adds_stored++;
         else adds_rejected++;
      end else begin
         res.success = |live_entries;
         if (res.success) finds_hit++;
         else finds_absent++;
      end
      res.used = USED_W'(stored_count);
      pending_outcomes.push_back(res);
      scan_pos        = 0;
      live_entries    = '1;
      string_overflow = 1'b0;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatch_count < 40)
         $display("MISMATCH at cycle %0d: %s got %0d expected %0d",
                  cycle_count, what, got, want);
      mismatch_count++;
   endtask

   // Compare one response transfer with the oldest expected outcome.
   task automatic check_outcome();
      outcome_type want;
      if (pending_outcomes.size() == 0) begin
         report_mismatch("unexpected response, op", rsp_tuser, -1);
         return;
      end
      want = pending_outcomes.pop_front();
      checked_count++;
      if (rsp_tuser !== want.op) report_mismatch("op", rsp_tuser, want.op);
      if (rsp_tdata[0] !== want.success)
         report_mismatch("success", rsp_tdata[0], want.success);
      if (rsp_tdata[USED_W:1] !== want.used)
         report_mismatch("entries_used", rsp_tdata[USED_W:1], want.used);
      if (rsp_tdata[RSP_DATA_W-1:USED_W+1] !== '0)
         report_mismatch("tdata padding", rsp_tdata[RSP_DATA_W-1:USED_W+1], 0);
   endtask

   // Monitor both channels at each edge; prediction comes before the check.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) track_string_byte(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) check_outcome();
      end
   end

   // Response sink: ready drops in randomly timed bursts of random length.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!reset && sink_stalls && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 18) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_outcomes.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Send one byte and wait for its transfer; valid stays high afterwards.
   task automatic send_byte(input logic mode_bit, input logic [CH_W-1:0] ch);
      int gap;
      if (src_gaps && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 18);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tuser  <= mode_bit;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   // Mode only matters on the first byte; later bytes carry a random one.
   task automatic send_string(input logic op_mode, input text_buf_type txt, input int len);
      for (int k = 0; k < len; k++)
         send_byte((k == 0) ? op_mode : 1'($urandom_range(0, 1)), txt[k]);
      send_byte((len == 0) ? op_mode : 1'($urandom_range(0, 1)), 8'h00);
   endtask

   function automatic void fill_random(inout text_buf_type txt, input int from,
                                       input int upto);
      for (int k = from; k < upto; k++) txt[k] = CH_W'($urandom_range(1, 255));
   endfunction

   // Pick a string: a stored entry, a near miss of one, or something fresh.
   function automatic void choose_text(output text_buf_type txt, output int len);
      int kind, idx, k, grow;
      logic [CH_W-1:0] v;
      kind = $urandom_range(0, 99);
      len  = 0;
      if (stored_count > 0 && kind < 76) begin
         idx = $urandom_range(0, stored_count - 1);
         while (len < SLOT_BYTES && stored_bytes[idx][len] != 0) begin
            txt[len] = stored_bytes[idx][len];
            len++;
         end
         if (kind >= 40 && kind < 52 && len > 0) begin
            len--;                                  // drop the last character
         end else if (kind >= 52 && kind < 64) begin
            grow = $urandom_range(1, 3);            // append characters
            if (len + grow > MAX_TEXT) grow = MAX_TEXT - len;
            fill_random(txt, len, len + grow);
            len += grow;
         end else if (kind >= 64 && len > 0) begin
            k = $urandom_range(0, len - 1);         // change one character
            do v = CH_W'($urandom_range(1, 255)); while (v == txt[k]);
            txt[k] = v;
         end
      end else if (kind < 93) begin
         len = $urandom_range(1, 8);
         fill_random(txt, 0, len);
      end else if (kind < 97) begin
         len = $urandom_range(SLOT_BYTES - 4, 40);
         fill_random(txt, 0, len);
      end
   endfunction

   // Empty strings on an empty table and after an empty entry is stored, then a one-character find.
   task automatic test_empty_strings();
      text_buf_type txt;
      txt[0] = 8'h41;
      send_string(swt_pkg::OP_FIND, txt, 0);
      send_string(swt_pkg::OP_ADD, txt, 0);
      send_string(swt_pkg::OP_FIND, txt, 0);
      send_string(swt_pkg::OP_FIND, txt, 1);
   endtask

   // Longest string that fits, one byte too long, and a saturating find.
   task automatic test_length_limits();
      text_buf_type txt;
      fill_random(txt, 0, 40);
      send_string(swt_pkg::OP_ADD, txt, SLOT_BYTES - 1);
      send_string(swt_pkg::OP_FIND, txt, SLOT_BYTES - 1);
      send_string(swt_pkg::OP_FIND, txt, SLOT_BYTES - 2);
      send_string(swt_pkg::OP_ADD, txt, SLOT_BYTES);
      send_string(swt_pkg::OP_FIND, txt, SLOT_BYTES);
      send_string(swt_pkg::OP_FIND, txt, 40);
      send_string(swt_pkg::OP_ADD, txt, 40);
   endtask

   // Characters at the ends of the byte range and single-bit neighbors.
   task automatic test_character_extremes();
      text_buf_type txt;
      txt[0] = 8'hFF; txt[1] = 8'h01; txt[2] = 8'h80;
      txt[3] = 8'h7F; txt[4] = 8'h55; txt[5] = 8'hAA;
      send_string(swt_pkg::OP_ADD, txt, 6);
      send_string(swt_pkg::OP_FIND, txt, 6);
      txt[2] = 8'h81;
      send_string(swt_pkg::OP_FIND, txt, 6);
   endtask

   // Fill the remaining slots, then show that a full table rejects adds.
   task automatic test_table_full();
      text_buf_type txt;
      int len;
      repeat (ENTRIES - 3) begin
         len = $urandom_range(1, 6);
         fill_random(txt, 0, len);
         send_string(swt_pkg::OP_ADD, txt, len);
      end
      fill_random(txt, 0, 5);
      send_string(swt_pkg::OP_ADD, txt, 5);
      send_string(swt_pkg::OP_FIND, txt, 5);
      send_string(swt_pkg::OP_ADD, txt, 0);
      send_string(swt_pkg::OP_FIND, txt, 0);
   endtask

   // Mixed random traffic until the byte budget is spent.
   task automatic test_random_traffic(input int byte_budget, input bit gaps,
                                      input bit stalls);
      text_buf_type txt;
      int len, start;
      src_gaps    = gaps;
      sink_stalls = stalls;
      start = bytes_sent;
      while (bytes_sent - start < byte_budget) begin
         choose_text(txt, len);
         send_string(($urandom_range(0, 99) < 15) ? swt_pkg::OP_ADD : swt_pkg::OP_FIND,
                     txt, len);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      src_gaps    = 1'b1;
      sink_stalls = 1'b1;
      test_empty_strings();
      test_length_limits();
      test_character_extremes();
      test_table_full();

      test_random_traffic(600, 1'b1, 1'b1);
      test_random_traffic(150, 1'b0, 1'b0);
      test_random_traffic(400, 1'b1, 1'b1);
      test_random_traffic(250, 1'b0, 1'b0);
      req_tvalid <= 1'b0;

      // Drain the outstanding responses, then idle before the summary.
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d string bytes: %0d adds stored, %0d adds rejected,",
               bytes_sent, adds_stored, adds_rejected);
      $display("%0d finds hit, %0d finds absent; checked %0d responses, %0d mismatches.",
               finds_hit, finds_absent, checked_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
